// ===== rtl/core/sdne_pkg.sv =====
package sdne_pkg;

  localparam int SampleW = 16;
  localparam int PosW    = 32;
  localparam int CountW  = 21;
  localparam int SumW    = 37;
  localparam int SqW     = 53;
  localparam int DSumW   = 38;
  localparam int ProdW   = 75;
  localparam int DenW    = 43;
  localparam int QuotCntW = $clog2(ProdW);
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [CountW-1:0] MaxSamples    = CountW'(1048576);
  localparam logic [CountW-1:0] MinDiffsFloor = CountW'(16);
  localparam logic [CountW-1:0] MinPairs      = CountW'(2);

  // floor(n/20) == (n * 838861) >> 24 for every n below 2^21
  localparam logic [19:0] Div20Mul   = 20'd838861;
  localparam int          Div20Shift = 24;

  localparam logic [1:0] RegMaxGap       = 2'd0;
  localparam logic [1:0] RegMinDiffCount = 2'd1;
  localparam logic [1:0] RegAutoMinDiffs = 2'd2;

  typedef struct packed {
    logic [15:0]       max_gap;
    logic [CountW-1:0] min_diff_count;
    logic              auto_thr;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0]       sample_count;
    logic [SumW-1:0]         sum_samples;
    logic [SqW-1:0]          sum_squares;
    logic [CountW-1:0]       pair_count;
    logic signed [DSumW-1:0] sum_diffs;
    logic [SqW-1:0]          sum_diff_squares;
  } snap_t;

  typedef enum logic [3:0] {
    BkIdle, BkMulNq, BkMulSs, BkMeanGo, BkMeanWait, BkTvGo, BkTvWait,
    BkMulMe, BkMulDd, BkNvGo, BkNvWait, BkOut
  } bk_state_e;

endpackage

// ===== rtl/core/successive_difference_noise_estimator.sv =====
// Front: one sample accepted per cycle into exact running sums (the first 2^20
// of a series); a sample is taken whenever the two-entry series queue has room.
// Back: per finished series, shift-add multiplies (one bit per cycle) and three
// 75-step restoring divisions; a result waits while the output register is held.
// Reset (async, active low) clears all sums, the queue and the output valid.
module successive_difference_noise_estimator import sdne_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic signed [31:0] position_i,
  input  logic        last_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mean_value_o,
  output logic [31:0] total_variance_o,
  output logic        stats_valid_o,
  output logic [32:0] noise_variance_o,
  output logic [20:0] diff_count_o,
  output logic        noise_valid_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push, pop, q_full, q_empty;
  snap_t push_data, pop_data;

  // registers always accept; the user must write only while the block is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_gap        <= '0;
      cfg_q.min_diff_count <= MinDiffsFloor;
      cfg_q.auto_thr       <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxGap:       cfg_q.max_gap        <= cfg_data_i[15:0];
        RegMinDiffCount: cfg_q.min_diff_count <= cfg_data_i;
        RegAutoMinDiffs: cfg_q.auto_thr       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // accumulate; a flagged sample hands the finished sums to the queue
  sdne_front u_front (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .position_i (position_i),
    .last_i,
    .q_full_i   (q_full),
    .push_o     (push),
    .snap_o     (push_data)
  );

  sdne_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_data)
  );

  // mean, variances, validity; result held in an output register
  sdne_back u_back (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .mean_value_o,
    .total_variance_o,
    .stats_valid_o,
    .noise_variance_o,
    .diff_count_o,
    .noise_valid_o
  );

endmodule

// ===== rtl/core/sdne_front.sv =====
module sdne_front import sdne_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [PosW-1:0]     position_i,
  input  logic                last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output snap_t               snap_o
);

  logic [CountW-1:0]       cnt_q, cnt_d;
  logic [SumW-1:0]         sum_q, sum_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [SampleW-1:0]      prev_s_q;
  logic [PosW-1:0]         prev_p_q;
  logic [CountW-1:0]       pairs_q, pairs_d;
  logic signed [DSumW-1:0] dsum_q, dsum_d;
  logic [SqW-1:0]          dsq_q, dsq_d;

  logic                    accept, upd, gap_ok;
  logic signed [PosW+1:0]  gap;
  logic signed [SampleW:0] diff;
  logic [SampleW-1:0]      abs_d;
  logic [2*SampleW-1:0]    s_sq, d_sq;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign upd        = cnt_q < MaxSamples;

  assign gap = $signed({{2{position_i[PosW-1]}}, position_i})
             - $signed({{2{prev_p_q[PosW-1]}}, prev_p_q}) - (PosW+2)'(1);
  assign gap_ok = gap <= $signed({(PosW+2-16)'(0), cfg_i.max_gap});

  assign diff  = $signed({1'b0, sample_i}) - $signed({1'b0, prev_s_q});
  assign abs_d = diff[SampleW] ? SampleW'(-diff) : diff[SampleW-1:0];
  assign s_sq  = (2*SampleW)'(sample_i) * (2*SampleW)'(sample_i);
  assign d_sq  = (2*SampleW)'(abs_d) * (2*SampleW)'(abs_d);

  always_comb begin
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    pairs_d = pairs_q;
    dsum_d  = dsum_q;
    dsq_d   = dsq_q;
    if (upd) begin
      cnt_d = cnt_q + CountW'(1);
      sum_d = sum_q + SumW'(sample_i);
      sq_d  = sq_q + SqW'(s_sq);
      if (cnt_q != '0 && gap_ok) begin
        pairs_d = pairs_q + CountW'(1);
        dsum_d  = dsum_q + DSumW'(diff);
        dsq_d   = dsq_q + SqW'(d_sq);
      end
    end
  end

  assign push_o = accept && last_i;
  assign snap_o = '{sample_count: cnt_d, sum_samples: sum_d, sum_squares: sq_d,
                    pair_count: pairs_d, sum_diffs: dsum_d, sum_diff_squares: dsq_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; sq_q <= '0; prev_s_q <= '0; prev_p_q <= '0;
      pairs_q <= '0; dsum_q <= '0; dsq_q <= '0;
    end else if (push_o) begin
      cnt_q <= '0; sum_q <= '0; sq_q <= '0; prev_s_q <= '0; prev_p_q <= '0;
      pairs_q <= '0; dsum_q <= '0; dsq_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d; sum_q <= sum_d; sq_q <= sq_d;
      pairs_q <= pairs_d; dsum_q <= dsum_d; dsq_q <= dsq_d;
      if (upd) begin
        prev_s_q <= sample_i;
        prev_p_q <= position_i;
      end
    end
  end

endmodule

// ===== rtl/core/sdne_queue.sv =====
module sdne_queue import sdne_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  snap_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output snap_t data_o
);

  snap_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QueuePtrW'(1);
      if (pop_i) rd_q <= rd_q + QueuePtrW'(1);
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

endmodule

// ===== rtl/core/sdne_div.sv =====
module sdne_div import sdne_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] num_i,
  input  logic [DenW-1:0]  den_i,
  output logic             done_o,
  output logic [ProdW-1:0] quot_o
);

  logic                busy_q, done_q;
  logic [QuotCntW-1:0] cnt_q;
  logic [ProdW-1:0]    num_q, quot_q;
  logic [DenW-1:0]     den_q, rem_q;
  logic [DenW:0]       rem_sh, rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q, num_q[ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[ProdW-2:0], 1'b0};
      rem_q  <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      quot_q <= {quot_q[ProdW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QuotCntW'(ProdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - QuotCntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sdne_back.sv =====
module sdne_back import sdne_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_empty_i,
  input  snap_t        q_data_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [15:0]  mean_value_o,
  output logic [31:0]  total_variance_o,
  output logic         stats_valid_o,
  output logic [32:0]  noise_variance_o,
  output logic [20:0]  diff_count_o,
  output logic         noise_valid_o
);

  bk_state_e state_q, state_d;

  snap_t             snap_q;
  logic [ProdW-1:0]  p1_q, num_q, acc_q, mul_a_q;
  logic [SumW-1:0]   mul_b_q;
  logic [DenW-1:0]   den_t_q, den_n_q;
  logic [CountW-1:0] n20_q;
  logic [15:0]       mean_q;
  logic [31:0]       tvar_q;
  logic [32:0]       nvar_q;

  logic              mul_done, div_start, div_done, out_load;
  logic [ProdW-1:0]  div_num, div_quot, diffv;
  logic [DenW-1:0]   div_den;
  logic [SumW-1:0]   d_abs;
  logic [DSumW-1:0]  d_neg;
  logic [CountW-1:0] thr;
  logic              sv, nv;
  logic [2*CountW-1:0] nn1, mm1;
  logic [CountW+19:0]  n20p;

  sdne_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mul_done = mul_b_q == '0;
  assign diffv    = (p1_q >= acc_q) ? p1_q - acc_q : '0;
  assign d_neg    = -snap_q.sum_diffs;
  assign d_abs    = snap_q.sum_diffs[DSumW-1] ? d_neg[SumW-1:0] : snap_q.sum_diffs[SumW-1:0];

  assign nn1  = (2*CountW)'(q_data_i.sample_count)
              * (2*CountW)'(q_data_i.sample_count - CountW'(1));
  assign mm1  = (2*CountW)'(q_data_i.pair_count)
              * (2*CountW)'(q_data_i.pair_count - CountW'(1));
  assign n20p = (CountW+20)'(q_data_i.sample_count) * (CountW+20)'(Div20Mul);

  assign sv  = snap_q.sample_count >= MinPairs;
  assign thr = cfg_i.auto_thr ? ((n20_q > MinDiffsFloor) ? n20_q : MinDiffsFloor)
                              : cfg_i.min_diff_count;
  assign nv  = sv && snap_q.pair_count >= MinPairs && snap_q.pair_count >= thr;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = den_t_q;
    out_load  = 1'b0;
    unique case (state_q)
      BkIdle: if (!q_empty_i) begin
        pop_o   = 1'b1;
        state_d = BkMulNq;
      end
      BkMulNq: if (mul_done) state_d = BkMulSs;
      BkMulSs: if (mul_done) state_d = BkMeanGo;
      BkMeanGo: begin
        div_start = 1'b1;
        div_num   = ProdW'(snap_q.sum_samples);
        div_den   = DenW'(snap_q.sample_count);
        state_d   = BkMeanWait;
      end
      BkMeanWait: if (div_done) state_d = BkTvGo;
      BkTvGo: begin
        div_start = 1'b1;
        state_d   = BkTvWait;
      end
      BkTvWait: if (div_done) state_d = BkMulMe;
      BkMulMe: if (mul_done) state_d = BkMulDd;
      BkMulDd: if (mul_done) state_d = BkNvGo;
      BkNvGo: begin
        div_start = 1'b1;
        div_den   = den_n_q;
        state_d   = BkNvWait;
      end
      BkNvWait: if (div_done) state_d = BkOut;
      BkOut: if (!out_valid_o || out_ready_i) begin
        out_load = 1'b1;
        state_d  = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // shift-add multiplier steps and result capture
  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: if (!q_empty_i) begin
        snap_q  <= q_data_i;
        den_t_q <= DenW'(nn1);
        den_n_q <= {mm1, 1'b0};
        n20_q   <= CountW'(n20p >> Div20Shift);
        acc_q   <= '0;
        mul_a_q <= ProdW'(q_data_i.sum_squares);
        mul_b_q <= SumW'(q_data_i.sample_count);
      end
      BkMulNq, BkMulSs, BkMulMe, BkMulDd: begin
        if (mul_done) begin
          if (state_q == BkMulNq || state_q == BkMulMe) begin
            p1_q    <= acc_q;
            acc_q   <= '0;
            mul_a_q <= (state_q == BkMulNq) ? ProdW'(snap_q.sum_samples) : ProdW'(d_abs);
            mul_b_q <= (state_q == BkMulNq) ? snap_q.sum_samples : d_abs;
          end else begin
            num_q <= diffv;
          end
        end else begin
          if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
          mul_a_q <= {mul_a_q[ProdW-2:0], 1'b0};
          mul_b_q <= {1'b0, mul_b_q[SumW-1:1]};
        end
      end
      BkMeanWait: if (div_done) mean_q <= div_quot[15:0];
      BkTvWait: if (div_done) begin
        tvar_q  <= (|div_quot[ProdW-1:32]) ? '1 : div_quot[31:0];
        acc_q   <= '0;
        mul_a_q <= ProdW'(snap_q.sum_diff_squares);
        mul_b_q <= SumW'(snap_q.pair_count);
      end
      BkNvWait: if (div_done) nvar_q <= (|div_quot[ProdW-1:33]) ? '1 : div_quot[32:0];
      BkOut: if (out_load) begin
        mean_value_o     <= sv ? mean_q : '0;
        total_variance_o <= sv ? tvar_q : '0;
        stats_valid_o    <= sv;
        noise_variance_o <= nv ? nvar_q : '0;
        diff_count_o     <= nv ? snap_q.pair_count : '0;
        noise_valid_o    <= nv;
      end
      default: ;
    endcase
  end

endmodule
